// File: rtl/bqlpf_pkg.sv
// ---------------------------------------------------------------------------
// bqlpf_pkg: shared types and constants of the biquad low-pass filter
// Register indexes, reset coefficients and the microcode program of the
// filter sequencer.
// ---------------------------------------------------------------------------
package bqlpf_pkg;

	localparam int COEF_BITS    = 24;
	localparam int DELAY_BITS   = 48;
	localparam int LO_BITS      = 24;
	localparam int REM_BITS     = COEF_BITS + 2;
	localparam int CFG_IDX_BITS = 3;
	localparam int PC_BITS      = 5;

	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	typedef logic [PC_BITS-1:0]      pc_t;

	localparam cfg_idx_t REG_B0 = 3'd0;
	localparam cfg_idx_t REG_B1 = 3'd1;
	localparam cfg_idx_t REG_B2 = 3'd2;
	localparam cfg_idx_t REG_A1 = 3'd3;
	localparam cfg_idx_t REG_A2 = 3'd4;

	localparam logic signed [COEF_BITS-1:0] B0_RST = 24'sd639;
	localparam logic signed [COEF_BITS-1:0] B1_RST = 24'sd1279;
	localparam logic signed [COEF_BITS-1:0] B2_RST = 24'sd639;
	localparam logic signed [COEF_BITS-1:0] A1_RST = -24'sd2022640;
	localparam logic signed [COEF_BITS-1:0] A2_RST = 24'sd976624;

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_PRESET,
		OP_MUL,
		OP_NOP,
		OP_FORM_W,
		OP_FORM_Y
	} op_t;

	typedef enum logic [1:0] {
		ASEL_D1,
		ASEL_D2,
		ASEL_W
	} asel_t;

	typedef enum logic [2:0] {
		BSEL_B0,
		BSEL_B1,
		BSEL_B2,
		BSEL_A1,
		BSEL_A2
	} bsel_t;

	typedef enum logic [2:0] {
		JMP_NONE,
		JMP_WAIT_IN,
		JMP_NOREQ,
		JMP_LOOP,
		JMP_OUT,
		JMP_GOTO
	} jump_t;

	typedef struct packed {
		op_t   op;
		asel_t asel;
		logic  hi;
		bsel_t bsel;
		logic  acc_clr;
		jump_t jmp;
		pc_t   target;
	} cw_t;

	localparam pc_t PC_IDLE = 5'd0;
	localparam pc_t PC_DIV  = 5'd2;
	localparam pc_t PC_FB   = 5'd4;

	function automatic cw_t micro_rom(input pc_t pc);
		cw_t cw;
		cw = '{op: OP_NOP, asel: ASEL_D1, hi: 1'b0, bsel: BSEL_B0, acc_clr: 1'b0,
			jmp: JMP_NONE, target: PC_IDLE};
		unique case (pc)
			5'd0: begin
				cw.op  = OP_IDLE;
				cw.jmp = JMP_WAIT_IN;
			end
			5'd1: begin
				cw.op     = OP_DIV_INIT;
				cw.jmp    = JMP_NOREQ;
				cw.target = PC_FB;
			end
			5'd2: begin
				cw.op     = OP_DIV_STEP;
				cw.jmp    = JMP_LOOP;
				cw.target = PC_DIV;
			end
			5'd3: cw.op = OP_PRESET;
			5'd4: begin
				cw.op      = OP_MUL;
				cw.asel    = ASEL_D1;
				cw.bsel    = BSEL_A1;
				cw.acc_clr = 1'b1;
			end
			5'd5: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_D1;
				cw.hi   = 1'b1;
				cw.bsel = BSEL_A1;
			end
			5'd6: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_D2;
				cw.bsel = BSEL_A2;
			end
			5'd7: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_D2;
				cw.hi   = 1'b1;
				cw.bsel = BSEL_A2;
			end
			5'd8: cw.op = OP_NOP;
			5'd9: begin
				cw.op      = OP_FORM_W;
				cw.acc_clr = 1'b1;
			end
			5'd10: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_W;
				cw.bsel = BSEL_B0;
			end
			5'd11: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_W;
				cw.hi   = 1'b1;
				cw.bsel = BSEL_B0;
			end
			5'd12: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_D1;
				cw.bsel = BSEL_B1;
			end
			5'd13: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_D1;
				cw.hi   = 1'b1;
				cw.bsel = BSEL_B1;
			end
			5'd14: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_D2;
				cw.bsel = BSEL_B2;
			end
			5'd15: begin
				cw.op   = OP_MUL;
				cw.asel = ASEL_D2;
				cw.hi   = 1'b1;
				cw.bsel = BSEL_B2;
			end
			5'd16: cw.op = OP_NOP;
			5'd17: begin
				cw.op     = OP_FORM_Y;
				cw.jmp    = JMP_OUT;
				cw.target = PC_IDLE;
			end
			default: begin
				cw.op     = OP_NOP;
				cw.jmp    = JMP_GOTO;
				cw.target = PC_IDLE;
			end
		endcase
		return cw;
	endfunction

endpackage

// File: rtl/biquad_lowpass_filter_unit.sv
// ---------------------------------------------------------------------------
// biquad_lowpass_filter_unit: second-order direct form II low-pass filter
// Microcoded sequencer driving one shared 25x24 multiplier, an accumulator
// and a bit-serial divider for the delay preset.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, req_type, sample): one transaction per
//   sample. req_type 1 presets both delays to the resting value for the
//   sample before filtering it.
//   Output channel (out_valid, out_stall, filtered, overflowed): one
//   transaction per input sample, in order.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
//   b0, b1, b2, a1, a2 (indexes 0 to 4), Q3.20; cfg_ready is always high.
//   Write coefficients only while the filter is idle.
// Timing:
//   A plain sample passes through the shared multiplier, which runs ten
//   partial products in sequence; the next sample is accepted only once the
//   sequencer has formed the result of the last one. A preset adds a
//   bit-serial division ahead of filtering, at one quotient bit per cycle.
//   The next sample is accepted while a result still waits in the output
//   register; a stalled result holds the sequencer at its final step.
// Reset: delays clear to zero, coefficients take their reset values and
// both channels go idle.
// ---------------------------------------------------------------------------
module biquad_lowpass_filter_unit #(
	parameter int SAMPLE_BITS     = 16,
	parameter int COEF_FRAC_BITS  = 20,
	parameter int STATE_FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [SAMPLE_BITS-1:0]         filtered,
	output logic                                  overflowed,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [bqlpf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic signed [bqlpf_pkg::COEF_BITS-1:0] cfg_data
);
	import bqlpf_pkg::*;

	localparam int DW  = (SAMPLE_BITS + STATE_FRAC_BITS > DELAY_BITS) ?
		SAMPLE_BITS + STATE_FRAC_BITS : DELAY_BITS;
	localparam int HW  = DW - LO_BITS;
	localparam int MA  = HW + 1;
	localparam int PW  = MA + COEF_BITS;
	localparam int AW  = DW + COEF_BITS + 2;
	localparam int NB  = SAMPLE_BITS + STATE_FRAC_BITS + COEF_FRAC_BITS;
	localparam int CNW = $clog2(NB + 1);
	localparam int YSH = STATE_FRAC_BITS + COEF_FRAC_BITS;

	localparam logic signed [AW-1:0] FB_HALF = AW'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [AW-1:0] Y_HALF  = AW'(1) <<< (YSH - 1);
	localparam logic [DELAY_BITS:0] LIM_POS = {2'b00, {(DELAY_BITS-1){1'b1}}};
	localparam logic [DELAY_BITS:0] LIM_NEG = {2'b01, {(DELAY_BITS-1){1'b0}}};
	localparam logic [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [COEF_BITS-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic signed [DW-1:0]        d1_q, d2_q, w_q;
	logic                        ovf_q;
	pc_t                         pc_q, pc_d;
	logic                        req_q;
	logic [SAMPLE_BITS-1:0]      x_q;
	logic signed [AW-1:0]        acc_q;
	logic signed [PW-1:0]        prod_s1;
	logic                        hi_s1;
	logic                        pv_s1;
	logic [SAMPLE_BITS-1:0]      mag_q;
	logic [REM_BITS-1:0]         r_q, d_q;
	logic [DELAY_BITS:0]         q_q;
	logic                        big_q, neg_q, zero_q;
	logic [CNW-1:0]              cnt_q;
	logic                        out_valid_q;
	logic signed [SAMPLE_BITS-1:0] y_q;
	logic                        ovf_out_q;

	cw_t                         cw;
	logic                        out_free;
	logic [DW-1:0]               a_word;
	logic signed [MA-1:0]        a_op;
	logic signed [COEF_BITS-1:0] b_op;
	logic signed [PW-1:0]        prod;
	logic signed [AW-1:0]        prod_ext, addend;
	logic signed [AW-1:0]        xs_a, fb_full, w_full, y_full;
	logic                        w_ok, y_ok;
	logic signed [DW-1:0]        w_next;
	logic [SAMPLE_BITS-1:0]      y_sat;
	logic signed [REM_BITS-1:0]  coef_sum;
	logic [REM_BITS:0]           rs, rsub;
	logic                        ge;
	logic [DELAY_BITS:0]         lim, qsat, pv;
	logic signed [DW-1:0]        preset_val;
	logic [SAMPLE_BITS-1:0]      mag_init;

	assign cw        = micro_rom(pc_q);
	assign in_stall  = (cw.jmp != JMP_WAIT_IN);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign filtered  = y_q;
	assign overflowed = ovf_out_q;

	always_comb begin
		unique case (cw.jmp)
			JMP_NONE:    pc_d = pc_q + 5'd1;
			JMP_WAIT_IN: pc_d = in_valid ? pc_q + 5'd1 : pc_q;
			JMP_NOREQ:   pc_d = req_q ? pc_q + 5'd1 : cw.target;
			JMP_LOOP:    pc_d = (cnt_q != CNW'(1)) ? cw.target : pc_q + 5'd1;
			JMP_OUT:     pc_d = out_free ? cw.target : pc_q;
			JMP_GOTO:    pc_d = cw.target;
			default:     pc_d = PC_IDLE;
		endcase
	end

	always_comb begin
		unique case (cw.asel)
			ASEL_D1: a_word = d1_q;
			ASEL_D2: a_word = d2_q;
			ASEL_W:  a_word = w_q;
			default: a_word = d1_q;
		endcase
		unique case (cw.bsel)
			BSEL_B0: b_op = b0_q;
			BSEL_B1: b_op = b1_q;
			BSEL_B2: b_op = b2_q;
			BSEL_A1: b_op = a1_q;
			BSEL_A2: b_op = a2_q;
			default: b_op = b0_q;
		endcase
		a_op = cw.hi ? {a_word[DW-1], a_word[DW-1:LO_BITS]}
			: {{(MA-LO_BITS){1'b0}}, a_word[LO_BITS-1:0]};
		prod = a_op * b_op;
	end

	always_comb begin
		prod_ext = AW'(prod_s1);
		addend   = hi_s1 ? (prod_ext <<< LO_BITS) : prod_ext;

		xs_a    = AW'($signed({x_q, {STATE_FRAC_BITS{1'b0}}}));
		fb_full = (acc_q + FB_HALF) >>> COEF_FRAC_BITS;
		w_full  = xs_a - fb_full;
		w_ok    = (&w_full[AW-1:DELAY_BITS-1]) | ~(|w_full[AW-1:DELAY_BITS-1]);
		w_next  = w_ok ? w_full[DW-1:0] : xs_a[DW-1:0];

		y_full = (acc_q + Y_HALF) >>> YSH;
		y_ok   = (&y_full[AW-1:SAMPLE_BITS-1]) | ~(|y_full[AW-1:SAMPLE_BITS-1]);
		y_sat  = y_ok ? y_full[SAMPLE_BITS-1:0] : (y_full[AW-1] ? Y_MIN : Y_MAX);
	end

	always_comb begin
		coef_sum = REM_BITS'(b0_q) + REM_BITS'(b1_q) + REM_BITS'(b2_q);
		mag_init = x_q[SAMPLE_BITS-1] ? (~x_q + 1'b1) : x_q;
		rs       = {r_q, mag_q[SAMPLE_BITS-1]};
		rsub     = rs - {1'b0, d_q};
		ge       = (rs >= {1'b0, d_q});
		lim      = neg_q ? LIM_NEG : LIM_POS;
		qsat     = (big_q || (q_q > lim)) ? lim : q_q;
		pv       = zero_q ? '0 : (neg_q ? (~qsat + 1'b1) : qsat);
		preset_val = DW'($signed(pv[DELAY_BITS-1:0]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= PC_IDLE;
			pv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			d1_q        <= '0;
			d2_q        <= '0;
			b0_q        <= B0_RST;
			b1_q        <= B1_RST;
			b2_q        <= B2_RST;
			a1_q        <= A1_RST;
			a2_q        <= A2_RST;
		end else begin
			pc_q  <= pc_d;
			pv_s1 <= (cw.op == OP_MUL);
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_B0:  b0_q <= cfg_data;
					REG_B1:  b1_q <= cfg_data;
					REG_B2:  b2_q <= cfg_data;
					REG_A1:  a1_q <= cfg_data;
					REG_A2:  a2_q <= cfg_data;
					default: ;
				endcase
			end
			if (cw.op == OP_FORM_Y && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cw.op == OP_PRESET) begin
				d1_q <= preset_val;
				d2_q <= preset_val;
			end
			if (cw.op == OP_FORM_Y && out_free) begin
				d2_q        <= d1_q;
				d1_q        <= w_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		hi_s1   <= cw.hi;
		if (cw.acc_clr) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + addend;
		end
		if (cw.jmp == JMP_WAIT_IN && in_valid) begin
			req_q <= req_type;
			x_q   <= sample;
		end
		if (cw.op == OP_DIV_INIT) begin
			mag_q  <= mag_init;
			r_q    <= '0;
			d_q    <= coef_sum;
			q_q    <= '0;
			neg_q  <= x_q[SAMPLE_BITS-1];
			zero_q <= (x_q == '0);
			big_q  <= coef_sum[REM_BITS-1] || (coef_sum == '0);
			cnt_q  <= CNW'(NB);
		end
		if (cw.op == OP_DIV_STEP) begin
			mag_q <= {mag_q[SAMPLE_BITS-2:0], 1'b0};
			r_q   <= ge ? rsub[REM_BITS-1:0] : rs[REM_BITS-1:0];
			q_q   <= {q_q[DELAY_BITS-1:0], ge};
			big_q <= big_q | q_q[DELAY_BITS];
			cnt_q <= cnt_q - CNW'(1);
		end
		if (cw.op == OP_FORM_W) begin
			w_q   <= w_next;
			ovf_q <= !w_ok;
		end
		if (cw.op == OP_FORM_Y && out_free) begin
			y_q       <= y_sat;
			ovf_out_q <= ovf_q;
		end
	end

endmodule
